[sv/patt_pkg.sv]
// Package for the poll arm / timeout tracker.
// Holds the action codes, register indexes, payload structs and default constants.
// No dependencies.
package patt_pkg;

  // Default width of the stored time stamp
  localparam int unsigned TimeBitsDefault = 48;

  // Fixed field widths
  localparam int unsigned NowW      = 48;
  localparam int unsigned TallyW    = 4;
  localparam int unsigned WindowW   = 16;
  localparam int unsigned TimeoutW  = 32;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 32;

  // Tally saturates here
  localparam logic [TallyW-1:0] TallyMax = 4'd15;

  // Register reset values
  localparam logic [TallyW-1:0]   ThresholdReset = 4'd4;
  localparam logic [WindowW-1:0]  WindowReset    = 16'd3000;
  localparam logic [TimeoutW-1:0] TimeoutReset   = 32'd0;

  // Register indexes on the configuration channel
  localparam logic [CfgAddrW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgWindow    = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgTimeout   = 2'd2;

  typedef enum logic [2:0] {
    ACT_POLL          = 3'd0,
    ACT_REFRESH       = 3'd1,
    ACT_TIMEOUT_CHECK = 3'd2,
    ACT_REQ_HOME      = 3'd3,
    ACT_CONSUME_HOME  = 3'd4,
    ACT_HOME_RETRY    = 3'd5,
    ACT_TIMEOUT_RETRY = 3'd6,
    ACT_RESET         = 3'd7
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [NowW-1:0]   now_ms;
    logic              eligible;
  } in_item_t;

  typedef struct packed {
    logic              fired;
    logic [NowW-1:0]   last_poll_time;
    logic [TallyW-1:0] polls_counted;
    logic              is_armed;
    logic              timeout_taken;
    logic              home_pending;
  } out_item_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

[sv/patt_stream_if.sv]
// Valid/ready channel interface used for input, result and configuration items.
// Payload type is a parameter; depends on nothing else.
interface patt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/poll_arm_timeout_tracker.sv]
// An item is registered in the input stage on accept; its result is registered in the
// result register as the stage advances; a held result not taken by out_o.ready stalls it.
// Throughput: one item per cycle while out_o.ready takes results; the single subtract-and-
// compare on the stored stamp, done in the same cycle as the state update, sets that figure.
// Reset: rst_ni clears tracking state, flags and handshakes, and loads register defaults.
// Top level of the poll arm / timeout tracker; uses patt_pkg and patt_stream_if.
module poll_arm_timeout_tracker
  import patt_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  patt_stream_if.sink         in_i,
  patt_stream_if.source       out_o,
  patt_stream_if.sink         cfg_i
);

  // Configuration registers
  logic [TallyW-1:0]   threshold_q;
  logic [WindowW-1:0]  window_q;
  logic [TimeoutW-1:0] timeout_q;

  // Tracking state
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [TallyW-1:0]    tally_q, tally_d;
  logic                 armed_q, armed_d;
  logic                 used_q, used_d;
  logic                 home_q, home_d;

  // Input stage and result register
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      fired_d;
  logic      advance;

  // Datapath helpers
  logic [63:0]          now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS:0]   diff;
  logic                 time_fwd;
  logic                 in_window;
  logic                 timed_out;
  logic [TallyW-1:0]    tally_inc;
  logic [63:0]          last_wide;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      window_q    <= WindowReset;
      timeout_q   <= TimeoutReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CfgThreshold: threshold_q <= cfg_i.data.data[TallyW-1:0];
        CfgWindow:    window_q    <= cfg_i.data.data[WindowW-1:0];
        CfgTimeout:   timeout_q   <= cfg_i.data.data[TimeoutW-1:0];
        default:      ;
      endcase
    end
  end

  // Handshake: the input stage moves on when the result register is free or drains
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  // Time difference against the stored stamp
  assign now_wide  = {{(64 - NowW){1'b0}}, s1_item_q.now_ms};
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign diff      = {1'b0, now_t} - {1'b0, last_q};
  assign time_fwd  = !diff[TIME_BITS];
  assign in_window = time_fwd &&
                     (64'(diff[TIME_BITS-1:0]) <= 64'(window_q));
  assign timed_out = time_fwd &&
                     (64'(diff[TIME_BITS-1:0]) >= 64'(timeout_q));
  assign tally_inc = (tally_q < TallyMax) ? tally_q + 1'b1 : tally_q;

  // Next state and fired flag for the item in the input stage
  always_comb begin
    last_d  = last_q;
    tally_d = tally_q;
    armed_d = armed_q;
    used_d  = used_q;
    home_d  = home_q;
    fired_d = 1'b0;
    case (s1_item_q.action)
      ACT_POLL: begin
        last_d = now_t;
        if (!armed_q) begin
          tally_d = (tally_q != '0 && in_window) ? tally_inc : TallyW'(1);
          if (tally_d >= threshold_q) begin
            armed_d = 1'b1;
            used_d  = 1'b0;
            fired_d = 1'b1;
          end
        end
      end
      ACT_REFRESH: begin
        if (armed_q) last_d = now_t;
      end
      ACT_TIMEOUT_CHECK: begin
        if (!s1_item_q.eligible) begin
          last_d  = '0;
          tally_d = '0;
          armed_d = 1'b0;
          used_d  = 1'b0;
        end else if (timeout_q != '0 && armed_q && timed_out && !used_q) begin
          used_d  = 1'b1;
          fired_d = 1'b1;
        end
      end
      ACT_REQ_HOME: begin
        last_d  = '0;
        tally_d = '0;
        armed_d = 1'b0;
        used_d  = 1'b0;
        home_d  = 1'b1;
      end
      ACT_CONSUME_HOME: begin
        fired_d = home_q;
        home_d  = 1'b0;
      end
      ACT_HOME_RETRY: begin
        home_d = 1'b1;
      end
      ACT_TIMEOUT_RETRY: begin
        if (armed_q) used_d = 1'b0;
      end
      default: begin
        last_d  = '0;
        tally_d = '0;
        armed_d = 1'b0;
        used_d  = 1'b0;
        home_d  = 1'b0;
      end
    endcase
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      tally_q <= '0;
      armed_q <= 1'b0;
      used_q  <= 1'b0;
      home_q  <= 1'b0;
    end else if (advance) begin
      last_q  <= last_d;
      tally_q <= tally_d;
      armed_q <= armed_d;
      used_q  <= used_d;
      home_q  <= home_d;
    end
  end

  // Result register: snapshot after the update
  assign last_wide = 64'(last_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.fired          <= fired_d;
      out_item_q.last_poll_time <= last_wide[NowW-1:0];
      out_item_q.polls_counted  <= tally_d;
      out_item_q.is_armed       <= armed_d;
      out_item_q.timeout_taken  <= used_d;
      out_item_q.home_pending   <= home_d;
    end
  end

`ifndef SYNTHESIS
  // The timeout can only be marked used on an armed session
  a_used_needs_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q |-> armed_q)
    else $error("timeout used flag set while not armed");

  // A stalled input stage keeps its item
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input stage lost or changed a stalled item");

  // State only moves when an item is processed
  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(armed_q) && $stable(home_q) && $stable(tally_q)))
    else $error("tracking state changed without an item");

  // A fired result on arming always reports an armed session
  a_fire_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_item_q.action == ACT_POLL && fired_d) |=> armed_q)
    else $error("poll fired without arming");
`endif

endmodule
